// ===== design/mhv_pkg.sv =====
// shared types and codes for the mixed heat-bath / voter spin update block
`timescale 1ns / 1ps
`default_nettype none
package mhv_pkg;

   localparam int COORD_W = 6;
   localparam int RAND_W  = 16;
   localparam int COUP_W  = 16;
   localparam int PROB_W  = 17;

   localparam logic [1:0] REQ_WRITE  = 2'd0;
   localparam logic [1:0] REQ_UPDATE = 2'd1;
   localparam logic [1:0] REQ_READ   = 2'd2;

   localparam logic [1:0] DIR_RIGHT = 2'd0;
   localparam logic [1:0] DIR_UP    = 2'd1;
   localparam logic [1:0] DIR_LEFT  = 2'd2;
   localparam logic [1:0] DIR_DOWN  = 2'd3;

   localparam logic [1:0] RDSEL_SELF_UP   = 2'd0;
   localparam logic [1:0] RDSEL_DOWN_LEFT = 2'd1;
   localparam logic [1:0] RDSEL_RIGHT     = 2'd2;

   localparam logic [1:0] CAP_NONE      = 2'd0;
   localparam logic [1:0] CAP_SELF_UP   = 2'd1;
   localparam logic [1:0] CAP_DOWN_LEFT = 2'd2;
   localparam logic [1:0] CAP_RIGHT     = 2'd3;

   localparam logic [1:0] RSP_NONE   = 2'd0;
   localparam logic [1:0] RSP_WRITE  = 2'd1;
   localparam logic [1:0] RSP_READ   = 2'd2;
   localparam logic [1:0] RSP_UPDATE = 2'd3;

   typedef struct packed {
      logic       load;
      logic [1:0] rd_sel;
      logic [1:0] cap;
      logic [1:0] rsp;
   } mhv_cmd_type;

   typedef struct packed {
      logic is_update;
   } mhv_stat_type;

endpackage
`default_nettype wire

// ===== design/mixed_heatbath_voter_spin_update.sv =====
// top level: register port, sequencer and datapath of the spin update block
// write item: written in the write state, then answered; a new item is accepted only in idle
// read item: one lattice read and its registered data
// update item: five lattice reads over two read ports in the RD0, RD1 and RD2 states
//   and four registered field, multiply and divide steps
// synchronous active-high reset clears sequencer, result strobe and registers to 1.0
`timescale 1ns / 1ps
`default_nettype none
module mixed_heatbath_voter_spin_update #(
   parameter int SIDE       = 64,
   parameter int PROB_STEPS = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [1:0]                     req_type,
   input  wire logic [mhv_pkg::COORD_W-1:0]    req_row,
   input  wire logic [mhv_pkg::COORD_W-1:0]    req_col,
   input  wire logic                           req_spin_in,
   input  wire logic                           req_kind_in,
   input  wire logic [mhv_pkg::RAND_W-1:0]     req_rand_uniform,
   input  wire logic [1:0]                     req_neighbour_dir,
   output logic                                rsp_valid,
   output logic                                rsp_spin_out,
   output logic                                rsp_kind_out,
   output logic                                rsp_spin_changed,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [2:0]                     paddr,
   input  wire logic [31:0]                    pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import mhv_pkg::*;

   logic signed [COUP_W-1:0] coupling_ff, coupling_in;
   logic [PROB_W-1:0]        agree_ff, agree_in;
   logic                     csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_comb begin
      coupling_in = coupling_ff;
      agree_in    = agree_ff;
      if (csr_wr) begin
         if (paddr[2]) begin
            agree_in = pwdata[PROB_W-1:0];
         end else begin
            coupling_in = pwdata[COUP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coupling_ff <= 16'sd16384;
         agree_ff    <= 17'd65536;
      end else begin
         coupling_ff <= coupling_in;
         agree_ff    <= agree_in;
      end
   end

   assign prdata = paddr[2] ? {{(32 - PROB_W){1'b0}}, agree_ff}
                            : {{(32 - COUP_W){coupling_ff[COUP_W-1]}}, coupling_ff};

   mhv_cmd_type  cmd;
   mhv_stat_type stat;

   mhv_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_type),
      .stat     (stat),
      .busy     (busy),
      .cmd      (cmd)
   );

   mhv_datapath #(
      .SIDE       (SIDE),
      .PROB_STEPS (PROB_STEPS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_type),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_spin_in       (req_spin_in),
      .req_kind_in       (req_kind_in),
      .req_rand_uniform  (req_rand_uniform),
      .req_neighbour_dir (req_neighbour_dir),
      .coupling          (coupling_ff),
      .agree_prob        (agree_ff),
      .rsp_valid         (rsp_valid),
      .rsp_spin_out      (rsp_spin_out),
      .rsp_kind_out      (rsp_kind_out),
      .rsp_spin_changed  (rsp_spin_changed)
   );

endmodule
`default_nettype wire

// ===== design/mhv_ctrl.sv =====
// sequencing state machine for site accesses
`timescale 1ns / 1ps
`default_nettype none
module mhv_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [1:0]            req_type,
   input  wire mhv_pkg::mhv_stat_type stat,
   output logic                       busy,
   output mhv_pkg::mhv_cmd_type       cmd
);
   import mhv_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_WRITE = 4'd1;
   localparam logic [3:0] ST_RD0   = 4'd2;
   localparam logic [3:0] ST_RDOUT = 4'd3;
   localparam logic [3:0] ST_RD1   = 4'd4;
   localparam logic [3:0] ST_RD2   = 4'd5;
   localparam logic [3:0] ST_RD3   = 4'd6;
   localparam logic [3:0] ST_SUM   = 4'd7;
   localparam logic [3:0] ST_MUL1  = 4'd8;
   localparam logic [3:0] ST_MUL2  = 4'd9;
   localparam logic [3:0] ST_MUL3  = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.rd_sel = RDSEL_SELF_UP;
      cmd.cap    = CAP_NONE;
      cmd.rsp    = RSP_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = (req_type == REQ_WRITE) ? ST_WRITE : ST_RD0;
            end
         end
         ST_WRITE: begin
            cmd.rsp  = RSP_WRITE;
            state_in = ST_IDLE;
         end
         ST_RD0: begin
            cmd.rd_sel = RDSEL_SELF_UP;
            state_in   = stat.is_update ? ST_RD1 : ST_RDOUT;
         end
         ST_RDOUT: begin
            cmd.rsp  = RSP_READ;
            state_in = ST_IDLE;
         end
         ST_RD1: begin
            cmd.cap    = CAP_SELF_UP;
            cmd.rd_sel = RDSEL_DOWN_LEFT;
            state_in   = ST_RD2;
         end
         ST_RD2: begin
            cmd.cap    = CAP_DOWN_LEFT;
            cmd.rd_sel = RDSEL_RIGHT;
            state_in   = ST_RD3;
         end
         ST_RD3: begin
            cmd.cap  = CAP_RIGHT;
            state_in = ST_SUM;
         end
         ST_SUM:  state_in = ST_MUL1;
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_DONE;
         ST_DONE: begin
            cmd.rsp  = RSP_UPDATE;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/mhv_datapath.sv =====
// lattice memory, neighbor capture, field sum, index arithmetic and result registers
`timescale 1ns / 1ps
`default_nettype none
module mhv_datapath #(
   parameter int SIDE       = 64,
   parameter int PROB_STEPS = 64
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire mhv_pkg::mhv_cmd_type           cmd,
   output mhv_pkg::mhv_stat_type               stat,
   input  wire logic [1:0]                     req_type,
   input  wire logic [mhv_pkg::COORD_W-1:0]    req_row,
   input  wire logic [mhv_pkg::COORD_W-1:0]    req_col,
   input  wire logic                           req_spin_in,
   input  wire logic                           req_kind_in,
   input  wire logic [mhv_pkg::RAND_W-1:0]     req_rand_uniform,
   input  wire logic [1:0]                     req_neighbour_dir,
   input  wire logic signed [mhv_pkg::COUP_W-1:0] coupling,
   input  wire logic [mhv_pkg::PROB_W-1:0]     agree_prob,
   output logic                                rsp_valid,
   output logic                                rsp_spin_out,
   output logic                                rsp_kind_out,
   output logic                                rsp_spin_changed
);
   import mhv_pkg::*;

   localparam int RW       = $clog2(SIDE);
   localparam int DEPTH    = SIDE * SIDE;
   localparam int AW       = $clog2(DEPTH);
   localparam int TAB_LEN  = 4 * PROB_STEPS + 1;
   localparam int TAB_MAX  = 4 * PROB_STEPS;
   localparam int IW       = $clog2(TAB_LEN);
   localparam int PW       = $clog2(PROB_STEPS + 1);
   localparam int HW       = 18;
   localparam int VW       = 28;
   localparam int VPW      = VW - 1 + PW;
   localparam int WW       = VPW - 15;
   localparam int RECIP_W  = 31;
   localparam int RECIP_SH = 40;
   localparam int QW       = WW + RECIP_W - RECIP_SH;
   localparam int MOD_LEN  = 2 ** COORD_W;

   localparam logic signed [HW-1:0] ONE_Q14  = 18'sd16384;
   localparam logic signed [VW-1:0] V_SCALE  = 28'sd625;
   localparam logic signed [VW-1:0] V_OFFSET = 28'sd40961024;
   localparam logic [RECIP_W-1:0]   RECIP_M  = 31'd1759218605;
   localparam longint unsigned Q30_ONE    = 64'd1073741824;
   localparam longint unsigned Q30_EXP_M1 = 64'd395007542;

   // shift-subtract long division for table construction
   function automatic longint unsigned quot_u64(input longint unsigned dividend,
                                                input longint unsigned divisor);
      longint unsigned quo, rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[62:0], dividend[b]};
         if (rem >= divisor) begin
            rem    = rem - divisor;
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // logistic probability in Q0.16 for entry idx, x = -8 + 4*idx/PROB_STEPS
   function automatic logic [16:0] logistic_entry(input int idx);
      longint s;
      longint unsigned num, q, r, term, pos, neg, e, den, p;
      s    = 4 * longint'(idx) - 8 * longint'(PROB_STEPS);
      num  = (s < 0) ? -s : s;
      q    = num / PROB_STEPS;
      r    = num % PROB_STEPS;
      term = Q30_ONE;
      pos  = Q30_ONE;
      neg  = 0;
      for (int k = 1; k <= 30; k++) begin
         term = quot_u64(term * r, 64'(PROB_STEPS * k));
         if ((k & 1) == 1) begin
            neg = neg + term;
         end else begin
            pos = pos + term;
         end
      end
      e = (pos > neg) ? pos - neg : 0;
      for (longint unsigned k = 0; k < q; k++) begin
         e = (e * Q30_EXP_M1) >> 30;
      end
      den = Q30_ONE + e;
      p   = quot_u64((64'd1 << 46) + (den >> 1), den);
      if (s < 0) begin
         p = 65536 - p;
      end
      return 17'(p);
   endfunction

   logic [16:0]   prob_tab [TAB_LEN];
   logic [RW-1:0] coord_mod [MOD_LEN];

   for (genvar g = 0; g < TAB_LEN; g++) begin : g_tab
      assign prob_tab[g] = logistic_entry(g);
   end

   for (genvar g = 0; g < MOD_LEN; g++) begin : g_mod
      assign coord_mod[g] = RW'(g % SIDE);
   end

   // latched item
   logic [1:0]        req_ff;
   logic [RW-1:0]     row_ff, col_ff;
   logic              spin_ff, kind_ff;
   logic [RAND_W-1:0] rnd_ff;
   logic [1:0]        dir_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff  <= req_type;
         row_ff  <= coord_mod[req_row];
         col_ff  <= coord_mod[req_col];
         spin_ff <= req_spin_in;
         kind_ff <= req_kind_in;
         rnd_ff  <= req_rand_uniform;
         dir_ff  <= req_neighbour_dir;
      end
   end

   assign stat.is_update = (req_ff == REQ_UPDATE);

   // neighbor addressing on the torus
   logic          row_top, row_bot;
   logic [RW-1:0] up_row, down_row, left_col, right_col;
   logic [AW-1:0] site_addr, up_addr, down_addr, left_addr, right_addr;

   assign row_top   = (row_ff == '0);
   assign row_bot   = (row_ff == RW'(SIDE - 1));
   assign up_row    = row_top ? RW'(SIDE - 1) : row_ff - 1'b1;
   assign down_row  = row_bot ? '0 : row_ff + 1'b1;
   assign left_col  = (col_ff == '0) ? RW'(SIDE - 1) : col_ff - 1'b1;
   assign right_col = (col_ff == RW'(SIDE - 1)) ? '0 : col_ff + 1'b1;

   assign site_addr  = AW'(row_ff) * AW'(SIDE) + AW'(col_ff);
   assign up_addr    = AW'(up_row) * AW'(SIDE) + AW'(col_ff);
   assign down_addr  = AW'(down_row) * AW'(SIDE) + AW'(col_ff);
   assign left_addr  = AW'(row_ff) * AW'(SIDE) + AW'(left_col);
   assign right_addr = AW'(row_ff) * AW'(SIDE) + AW'(right_col);

   // lattice memory, bit 1 kind, bit 0 spin
   logic [1:0]    lattice_ff [DEPTH];
   logic [1:0]    rd_a_ff, rd_b_ff;
   logic [AW-1:0] rd_addr_a, rd_addr_b;
   logic          we;
   logic [1:0]    wdata;

   always_comb begin
      case (cmd.rd_sel)
         RDSEL_DOWN_LEFT: begin
            rd_addr_a = down_addr;
            rd_addr_b = left_addr;
         end
         RDSEL_RIGHT: begin
            rd_addr_a = right_addr;
            rd_addr_b = right_addr;
         end
         default: begin
            rd_addr_a = site_addr;
            rd_addr_b = up_addr;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= lattice_ff[rd_addr_a];
      rd_b_ff <= lattice_ff[rd_addr_b];
      if (we) begin
         lattice_ff[site_addr] <= wdata;
      end
   end

   // neighbor capture
   logic self_spin_ff, self_kind_ff, up_ff, down_ff, left_ff, right_ff;

   always_ff @(posedge clock) begin
      case (cmd.cap)
         CAP_SELF_UP: begin
            self_spin_ff <= rd_a_ff[0];
            self_kind_ff <= rd_a_ff[1];
            up_ff        <= rd_b_ff[0];
         end
         CAP_DOWN_LEFT: begin
            down_ff <= rd_a_ff[0];
            left_ff <= rd_b_ff[0];
         end
         CAP_RIGHT: right_ff <= rd_a_ff[0];
         default: ;
      endcase
   end

   // local field and table index
   logic signed [HW-1:0] j_ext, su, sd, sl, sr, h_in, h_ff;
   logic signed [VW-1:0] h_ext, v_in, v_ff;
   logic [VPW-1:0]       vp_prod;
   logic [WW-1:0]        w_in, w_ff;
   logic [WW+RECIP_W-1:0] q_prod;
   logic [QW-1:0]        q_in, q_ff;

   assign j_ext = {{(HW - COUP_W){coupling[COUP_W-1]}}, coupling};
   assign su    = row_top ? (up_ff ? j_ext : -j_ext) : (up_ff ? ONE_Q14 : -ONE_Q14);
   assign sd    = row_bot ? (down_ff ? j_ext : -j_ext) : (down_ff ? ONE_Q14 : -ONE_Q14);
   assign sl    = left_ff ? ONE_Q14 : -ONE_Q14;
   assign sr    = right_ff ? ONE_Q14 : -ONE_Q14;
   assign h_in  = su + sd + sl + sr;

   assign h_ext   = {{(VW - HW){h_ff[HW-1]}}, h_ff};
   assign v_in    = h_ext * V_SCALE + V_OFFSET;
   assign vp_prod = VPW'(v_ff[VW-2:0]) * VPW'(PROB_STEPS);
   assign w_in    = (!v_ff[VW-1] && (v_ff != '0)) ? vp_prod[VPW-1:15] : '0;
   assign q_prod  = (WW + RECIP_W)'(w_ff) * (WW + RECIP_W)'(RECIP_M);
   assign q_in    = q_prod[WW+RECIP_W-1:RECIP_SH];

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      v_ff <= v_in;
      w_ff <= w_in;
      q_ff <= q_in;
   end

   // new spin
   logic [IW-1:0] idx;
   logic          heat_nw, nb, wrap_dir, voter_nw, nw;

   assign idx     = (q_ff > QW'(TAB_MAX)) ? IW'(TAB_MAX) : q_ff[IW-1:0];
   assign heat_nw = ({1'b0, rnd_ff} <= prob_tab[idx]);

   always_comb begin
      case (dir_ff)
         DIR_RIGHT: nb = right_ff;
         DIR_UP:    nb = up_ff;
         DIR_LEFT:  nb = left_ff;
         default:   nb = down_ff;
      endcase
   end

   assign wrap_dir = (row_top && (dir_ff == DIR_UP)) || (row_bot && (dir_ff == DIR_DOWN));
   assign voter_nw = wrap_dir ? (({1'b0, rnd_ff} <= agree_prob) ? nb : ~nb) : nb;
   assign nw       = self_kind_ff ? voter_nw : heat_nw;

   assign we    = (cmd.rsp == RSP_WRITE) || (cmd.rsp == RSP_UPDATE);
   assign wdata = (cmd.rsp == RSP_WRITE) ? {kind_ff, spin_ff} : {self_kind_ff, nw};

   // result registers
   logic rsp_valid_ff, rsp_spin_ff, rsp_kind_ff, rsp_changed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= (cmd.rsp != RSP_NONE);
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.rsp)
         RSP_WRITE: begin
            rsp_spin_ff    <= spin_ff;
            rsp_kind_ff    <= kind_ff;
            rsp_changed_ff <= 1'b0;
         end
         RSP_READ: begin
            rsp_spin_ff    <= rd_a_ff[0];
            rsp_kind_ff    <= rd_a_ff[1];
            rsp_changed_ff <= 1'b0;
         end
         RSP_UPDATE: begin
            rsp_spin_ff    <= nw;
            rsp_kind_ff    <= self_kind_ff;
            rsp_changed_ff <= nw ^ self_spin_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_spin_out     = rsp_spin_ff;
   assign rsp_kind_out     = rsp_kind_ff;
   assign rsp_spin_changed = rsp_changed_ff;

endmodule
`default_nettype wire

// ===== tb/tb_mixed_heatbath_voter_spin_update.sv =====
// testbench for the spin update block: site writes, reads and monte carlo updates checked against a lattice predictor
`timescale 1ns / 1ps
module tb_mixed_heatbath_voter_spin_update;
   import mhv_pkg::*;

   localparam int SIDE        = 64;
   localparam int PROB_STEPS  = 64;
   localparam int TAB_LEN     = 4 * PROB_STEPS + 1;
   localparam int SITES       = SIDE * SIDE;
   localparam int ONE_Q14     = 16384;
   localparam int PHASE_ITEMS = 40;
   localparam int TAIL_CYCLES = 12;
   localparam int CYCLE_LIMIT = 1000000;

   localparam logic [1:0] REQ_SPARE = 2'd3;

   localparam int CSR_BOUNDARY_COUPLING = 0;
   localparam int CSR_VOTER_AGREE_PROB  = 1;

   typedef struct packed {
      logic [1:0]         op;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               spin;
      logic               kind;
      logic [RAND_W-1:0]  rnd;
      logic [1:0]         dir;
   } site_req_type;

   typedef struct packed {
      logic spin;
      logic kind;
      logic changed;
   } site_rsp_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_type = REQ_WRITE;
   logic [COORD_W-1:0] req_row = '0;
   logic [COORD_W-1:0] req_col = '0;
   logic               req_spin_in = 1'b0;
   logic               req_kind_in = 1'b0;
   logic [RAND_W-1:0]  req_rand_uniform = '0;
   logic [1:0]         req_neighbour_dir = DIR_RIGHT;
   logic               rsp_valid;
   logic               rsp_spin_out;
   logic               rsp_kind_out;
   logic               rsp_spin_changed;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [2:0]         paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   mixed_heatbath_voter_spin_update #(
      .SIDE       (SIDE),
      .PROB_STEPS (PROB_STEPS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_row           (req_row),
      .req_col           (req_col),
      .req_spin_in       (req_spin_in),
      .req_kind_in       (req_kind_in),
      .req_rand_uniform  (req_rand_uniform),
      .req_neighbour_dir (req_neighbour_dir),
      .rsp_valid         (rsp_valid),
      .rsp_spin_out      (rsp_spin_out),
      .rsp_kind_out      (rsp_kind_out),
      .rsp_spin_changed  (rsp_spin_changed),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #5 clock = ~clock;

   bit           spin_mem [SITES];
   bit           kind_mem [SITES];
   bit           written  [SITES];
   logic [16:0]  logistic_prob [TAB_LEN];
   int           coupling_q14 = 16384;
   int unsigned  agree_prob   = 65536;
   site_rsp_type results_due [$];
   site_rsp_type checked_rsp;

   bit steady;
   int mismatches;
   int cycles;
   int results_checked;
   int n_writes;
   int n_updates;
   int n_reads;
   int n_flips;
   int n_settings;

   task automatic flag_mismatch(input string what);
      mismatches++;
      if (mismatches <= 40) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic longint unsigned decay_q30(input int unsigned num);
      longint unsigned term, pos, neg, e;
      int unsigned q, r;
      int k;
      q    = num / PROB_STEPS;
      r    = num % PROB_STEPS;
      term = 64'd1 << 30;
      pos  = term;
      neg  = 0;
      for (k = 1; k <= 30; k++) begin
         term = (term * r) / (PROB_STEPS * k);
         if (k % 2 == 1) neg += term;
         else pos += term;
      end
      e = (pos > neg) ? pos - neg : 64'd0;
      repeat (q) e = (e * 64'd395007542) >> 30;
      return e;
   endfunction

   function automatic void build_logistic_probs();
      longint s;
      longint unsigned num, den, p;
      int i;
      for (i = 0; i < TAB_LEN; i++) begin
         s   = 4 * i - 8 * PROB_STEPS;
         num = (s < 0) ? -s : s;
         den = (64'd1 << 30) + decay_q30(int'(num));
         p   = ((64'd1 << 46) + den / 2) / den;
         logistic_prob[i] = (s < 0) ? 17'(64'd65536 - p) : 17'(p);
      end
   endfunction

   function automatic int heat_bin(input int h);
      longint t, idx;
      t = longint'(h) * 10000 + longint'(40001) * ONE_Q14;
      if (t <= 0) return 0;
      idx = (t * PROB_STEPS) / 64'd327680000;
      if (idx > 4 * PROB_STEPS) idx = 4 * PROB_STEPS;
      return int'(idx);
   endfunction

   function automatic int spin_q14(input int r, input int c);
      return spin_mem[r * SIDE + c] ? ONE_Q14 : -ONE_Q14;
   endfunction

   function automatic site_rsp_type advance_lattice(input site_req_type it);
      int row, col, site, up, down, left, right, su, sd, h, nr, nc;
      bit old_spin, new_spin, nb;
      site_rsp_type res;
      row   = it.row % SIDE;
      col   = it.col % SIDE;
      site  = row * SIDE + col;
      up    = (row == 0) ? SIDE - 1 : row - 1;
      down  = (row == SIDE - 1) ? 0 : row + 1;
      left  = (col == 0) ? SIDE - 1 : col - 1;
      right = (col == SIDE - 1) ? 0 : col + 1;
      res.changed = 1'b0;
      case (it.op)
         REQ_WRITE: begin
            spin_mem[site] = it.spin;
            kind_mem[site] = it.kind;
            written[site]  = 1'b1;
         end
         REQ_UPDATE: begin
            old_spin = spin_mem[site];
            if (!kind_mem[site]) begin
               su = spin_q14(up, col);
               sd = spin_q14(down, col);
               // row-wrap neighbor is weighted by the coupling
               if (row == 0) su = (su > 0) ? coupling_q14 : -coupling_q14;
               else if (row == SIDE - 1) sd = (sd > 0) ? coupling_q14 : -coupling_q14;
               h = su + sd + spin_q14(row, left) + spin_q14(row, right);
               new_spin = (it.rnd <= logistic_prob[heat_bin(h)]);
            end else if ((row == 0 && it.dir == DIR_UP) ||
                         (row == SIDE - 1 && it.dir == DIR_DOWN)) begin
               nb = spin_mem[((it.dir == DIR_UP) ? up : down) * SIDE + col];
               new_spin = (it.rnd <= agree_prob) ? nb : !nb;
            end else begin
               nr = row;
               nc = col;
               case (it.dir)
                  DIR_RIGHT: nc = right;
                  DIR_UP:    nr = up;
                  DIR_LEFT:  nc = left;
                  default:   nr = down;
               endcase
               new_spin = spin_mem[nr * SIDE + nc];
            end
            spin_mem[site] = new_spin;
            res.changed = (new_spin != old_spin);
         end
         default: ;
      endcase
      res.spin = spin_mem[site];
      res.kind = kind_mem[site];
      return res;
   endfunction

   function automatic site_req_type make_req(input logic [1:0] op, input int row, input int col,
                                             input logic spin, input logic kind,
                                             input int rnd, input logic [1:0] dir);
      site_req_type it;
      it.op   = op;
      it.row  = COORD_W'(row);
      it.col  = COORD_W'(col);
      it.spin = spin;
      it.kind = kind;
      it.rnd  = RAND_W'(rnd);
      it.dir  = dir;
      return it;
   endfunction

   function automatic int pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic int pick_coord();
      if ($urandom_range(0, 9) < 7) begin
         case ($urandom_range(0, 3))
            0: return 0;
            1: return 1;
            2: return SIDE - 2;
            default: return SIDE - 1;
         endcase
      end
      return $urandom_range(0, SIDE - 1);
   endfunction

   // random numbers near the decision thresholds as well as plain ones
   function automatic int pick_rand();
      int unsigned roll;
      int v;
      roll = $urandom_range(0, 99);
      if (roll < 10) return 0;
      if (roll < 20) return 65535;
      if (roll < 45) begin
         if (roll < 35) v = int'(logistic_prob[$urandom_range(0, TAB_LEN - 1)]);
         else v = int'(agree_prob);
         v = v + int'($urandom_range(0, 2)) - 1;
         if (v < 0) v = 0;
         if (v > 65535) v = 65535;
         return v;
      end
      return $urandom_range(0, 65535);
   endfunction

   task automatic send_item(input site_req_type it);
      site_rsp_type res;
      int gap;
      start             <= 1'b1;
      req_type          <= it.op;
      req_row           <= it.row;
      req_col           <= it.col;
      req_spin_in       <= it.spin;
      req_kind_in       <= it.kind;
      req_rand_uniform  <= it.rnd;
      req_neighbour_dir <= it.dir;
      do @(posedge clock); while (busy !== 1'b0);
      res = advance_lattice(it);
      results_due.push_back(res);
      case (it.op)
         REQ_WRITE:  n_writes++;
         REQ_UPDATE: n_updates++;
         default:    n_reads++;
      endcase
      if (res.changed) n_flips++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic claim_site(input int row, input int col);
      if (!written[row * SIDE + col])
         send_item(make_req(REQ_WRITE, row, col, 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 0, DIR_RIGHT));
   endtask

   task automatic claim_neighbourhood(input int row, input int col);
      claim_site(row, col);
      claim_site((row + SIDE - 1) % SIDE, col);
      claim_site((row + 1) % SIDE, col);
      claim_site(row, (col + SIDE - 1) % SIDE);
      claim_site(row, (col + 1) % SIDE);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (results_due.size() != 0 || busy !== 1'b0);
   endtask

   task automatic csr_readback(input int idx);
      logic [31:0] got;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= 3'(idx * 4);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if (idx == CSR_BOUNDARY_COUPLING) begin
         if (got[15:0] !== 16'(coupling_q14))
            flag_mismatch($sformatf("coupling reads %h, want %h", got[15:0], 16'(coupling_q14)));
      end else if (got[16:0] !== 17'(agree_prob)) begin
         flag_mismatch($sformatf("agree prob reads %h, want %h", got[16:0], 17'(agree_prob)));
      end
   endtask

   task automatic csr_program(input int idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 3'(idx * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == CSR_BOUNDARY_COUPLING) coupling_q14 = int'($signed(value[15:0]));
      else agree_prob = 32'(value[16:0]);
      @(posedge clock);
      csr_readback(idx);
   endtask

   task automatic test_csr_reset();
      wait_idle();
      csr_readback(CSR_BOUNDARY_COUPLING);
      csr_readback(CSR_VOTER_AGREE_PROB);
      n_settings++;
   endtask

   task automatic test_directed_sites();
      send_item(make_req(REQ_WRITE, 0, 0, 1'b1, 1'b0, 0, DIR_RIGHT));
      send_item(make_req(REQ_WRITE, SIDE - 1, SIDE - 1, 1'b0, 1'b1, 65535, DIR_DOWN));
      send_item(make_req(REQ_READ, 0, 0, 1'b0, 1'b1, 0, DIR_RIGHT));
      send_item(make_req(REQ_SPARE, SIDE - 1, SIDE - 1, 1'b1, 1'b0, 65535, DIR_DOWN));
      claim_neighbourhood(0, 0);
      // heat-bath corner site, always up then always down
      send_item(make_req(REQ_UPDATE, 0, 0, 1'b0, 1'b0, 0, DIR_RIGHT));
      send_item(make_req(REQ_UPDATE, 0, 0, 1'b0, 1'b0, 65535, DIR_RIGHT));
      // voter corner site, every direction, boundary one first
      send_item(make_req(REQ_WRITE, 0, 0, 1'b0, 1'b1, 0, DIR_RIGHT));
      send_item(make_req(REQ_UPDATE, 0, 0, 1'b0, 1'b0, 65535, DIR_UP));
      send_item(make_req(REQ_UPDATE, 0, 0, 1'b1, 1'b1, 12345, DIR_RIGHT));
      send_item(make_req(REQ_UPDATE, 0, 0, 1'b0, 1'b0, 0, DIR_LEFT));
      send_item(make_req(REQ_UPDATE, 0, 0, 1'b1, 1'b1, 65535, DIR_DOWN));
      send_item(make_req(REQ_WRITE, SIDE - 1, SIDE - 1, 1'b1, 1'b0, 0, DIR_RIGHT));
      claim_neighbourhood(SIDE - 1, SIDE - 1);
      send_item(make_req(REQ_UPDATE, SIDE - 1, SIDE - 1, 1'b0, 1'b0, 32768, DIR_UP));
      send_item(make_req(REQ_WRITE, SIDE - 1, SIDE - 1, 1'b0, 1'b1, 0, DIR_RIGHT));
      send_item(make_req(REQ_UPDATE, SIDE - 1, SIDE - 1, 1'b1, 1'b0, 0, DIR_DOWN));
      send_item(make_req(REQ_READ, SIDE - 1, SIDE - 1, 1'b1, 1'b1, 65535, DIR_LEFT));
   endtask

   task automatic test_random_settings();
      int couplings [6];
      int probs [6];
      int k, n;
      int unsigned roll;
      site_req_type it;
      couplings = '{16384, -16384, 0, -1, 8192, 0};
      probs     = '{65536, 0, 131071, 65535, 32768, 0};
      couplings[5] = int'($urandom_range(0, 32768)) - 16384;
      probs[5]     = int'($urandom_range(0, 65536));
      for (k = 0; k < 6; k++) begin
         wait_idle();
         csr_program(CSR_BOUNDARY_COUPLING, 32'(couplings[k]));
         csr_program(CSR_VOTER_AGREE_PROB, 32'(probs[k]));
         n_settings++;
         steady = (k % 3 == 2);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) it.op = REQ_WRITE;
            else if (roll < 80) it.op = REQ_UPDATE;
            else if (roll < 95) it.op = REQ_READ;
            else it.op = REQ_SPARE;
            it.row  = COORD_W'(pick_coord());
            it.col  = COORD_W'(pick_coord());
            it.spin = 1'($urandom_range(0, 1));
            it.kind = 1'($urandom_range(0, 1));
            it.rnd  = RAND_W'(pick_rand());
            it.dir  = 2'($urandom_range(0, 3));
            if (it.op == REQ_UPDATE) claim_neighbourhood(int'(it.row), int'(it.col));
            else if (it.op != REQ_WRITE) claim_site(int'(it.row), int'(it.col));
            send_item(it);
         end
      end
      steady = 1'b0;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         if (results_due.size() == 0) begin
            flag_mismatch("result with no item outstanding");
         end else begin
            checked_rsp = results_due.pop_front();
            results_checked++;
            if (rsp_spin_out !== checked_rsp.spin)
               flag_mismatch($sformatf("spin_out %b, want %b", rsp_spin_out, checked_rsp.spin));
            if (rsp_kind_out !== checked_rsp.kind)
               flag_mismatch($sformatf("kind_out %b, want %b", rsp_kind_out, checked_rsp.kind));
            if (rsp_spin_changed !== checked_rsp.changed)
               flag_mismatch($sformatf("spin_changed %b, want %b", rsp_spin_changed,
                                       checked_rsp.changed));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("[mixed_heatbath_voter_spin_update] ERROR");
         $finish;
      end
   end

   initial begin
      build_logistic_probs();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_csr_reset();
      test_directed_sites();
      test_random_settings();
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (results_due.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", results_due.size()));
      $display("covered %0d writes, %0d updates (%0d spin flips), %0d reads",
               n_writes, n_updates, n_flips, n_reads);
      $display("under %0d register settings, %0d results compared, %0d mismatches",
               n_settings, results_checked, mismatches);
      if (mismatches == 0) begin
         $display("[mixed_heatbath_voter_spin_update] OK");
      end else begin
         $display("[mixed_heatbath_voter_spin_update] ERROR");
      end
      $finish;
   end

endmodule
